// File: design/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_PRESSED  = 3'd1,
    ST_RELEASED = 3'd2,
    ST_LONG     = 3'd3,
    ST_LONGEND  = 3'd4
  } bpc_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_LOW = 2'd0,
    CFG_DEBOUNCE   = 2'd1,
    CFG_PRESS      = 2'd2,
    CFG_LONG_PRESS = 2'd3
  } bpc_cfg_idx_t;

  typedef struct packed {
    logic            active_low;
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] press_ms;
    logic [MS_W-1:0] long_press_ms;
  } bpc_cfg_t;

  typedef struct packed {
    logic       short_press;
    logic       long_start;
    logic       long_stop;
    logic [2:0] button_state;
  } bpc_res_t;

endpackage
`default_nettype wire

// File: design/bpc_cfg.sv
`default_nettype none
module bpc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [bpc_pkg::MS_W-1:0]      wr_data,
  output bpc_pkg::bpc_cfg_t                  cfg
);
  import bpc_pkg::*;

  bpc_cfg_t cfg_r;
  bpc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (bpc_cfg_idx_t'(wr_index))
        CFG_ACTIVE_LOW: cfg_nxt.active_low    = wr_data[0];
        CFG_DEBOUNCE:   cfg_nxt.debounce_ms   = wr_data;
        CFG_PRESS:      cfg_nxt.press_ms      = wr_data;
        CFG_LONG_PRESS: cfg_nxt.long_press_ms = wr_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low    <= 1'b1;
      cfg_r.debounce_ms   <= MS_W'(50);
      cfg_r.press_ms      <= MS_W'(400);
      cfg_r.long_press_ms <= MS_W'(800);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: design/bpc_fsm.sv
`default_nettype none
module bpc_fsm (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic                       pin_level,
  input  wire logic [bpc_pkg::TIME_W-1:0] now_ms,
  input  wire bpc_pkg::bpc_cfg_t          cfg,
  output bpc_pkg::bpc_res_t               res
);
  import bpc_pkg::*;

  bpc_state_t        cur_r, cur_nxt;
  bpc_state_t        prev_r, prev_nxt;
  logic [TIME_W-1:0] stamp_r, stamp_nxt;

  logic [TIME_W-1:0] elapsed;
  logic              act;
  logic              lt_deb;
  logic              gt_press;
  logic              gt_long;

  assign elapsed  = now_ms - stamp_r;
  assign act      = pin_level ^ cfg.active_low;
  assign lt_deb   = elapsed < TIME_W'(cfg.debounce_ms);
  assign gt_press = elapsed > TIME_W'(cfg.press_ms);
  assign gt_long  = elapsed > TIME_W'(cfg.long_press_ms);

  always_comb begin
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    stamp_nxt = stamp_r;
    case (cur_r)
      ST_IDLE: begin
        if (act) begin
          prev_nxt  = cur_r;
          cur_nxt   = ST_PRESSED;
          stamp_nxt = now_ms;
        end
      end
      ST_PRESSED: begin
        if (!act && lt_deb) begin
          prev_nxt = cur_r;
          cur_nxt  = prev_r;
        end else if (!act) begin
          prev_nxt  = cur_r;
          cur_nxt   = ST_RELEASED;
          stamp_nxt = now_ms;
        end else if (gt_long) begin
          prev_nxt = cur_r;
          cur_nxt  = ST_LONG;
        end
      end
      ST_RELEASED: begin
        if (act && lt_deb) begin
          prev_nxt = cur_r;
          cur_nxt  = prev_r;
        end else if (!act && gt_press) begin
          prev_nxt  = ST_IDLE;
          cur_nxt   = ST_IDLE;
          stamp_nxt = '0;
        end
      end
      ST_LONG: begin
        if (!act) begin
          prev_nxt  = cur_r;
          cur_nxt   = ST_LONGEND;
          stamp_nxt = now_ms;
        end
      end
      ST_LONGEND: begin
        if (act && lt_deb) begin
          prev_nxt = cur_r;
          cur_nxt  = prev_r;
        end else if (!lt_deb) begin
          prev_nxt  = ST_IDLE;
          cur_nxt   = ST_IDLE;
          stamp_nxt = '0;
        end
      end
      default: begin
        prev_nxt = cur_r;
        cur_nxt  = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res              = '0;
    res.button_state = cur_nxt;
    case (cur_r)
      ST_PRESSED:  res.long_start  = act && gt_long;
      ST_RELEASED: res.short_press = !(act && lt_deb) && !act && gt_press;
      ST_LONGEND:  res.long_stop   = !lt_deb;
      default:     res.button_state = cur_nxt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= ST_IDLE;
      prev_r  <= ST_IDLE;
      stamp_r <= '0;
    end else if (adv) begin
      cur_r   <= cur_nxt;
      prev_r  <= prev_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> $onehot0({res.short_press, res.long_start, res.long_stop}))
    else $error("more than one event in a single poll");

  a_short_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.short_press |=> cur_r == ST_IDLE && prev_r == ST_IDLE && stamp_r == '0)
    else $error("short press did not clear state");

  a_long_enters: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.long_start |=> cur_r == ST_LONG && prev_r == ST_PRESSED)
    else $error("long press start did not enter long state");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cur_r) && $stable(prev_r) && $stable(stamp_r))
    else $error("state moved without a poll");

endmodule
`default_nettype wire

// File: design/button_press_classifier.sv
// Short/long press classifier for one button, polled once per request. Each
// request carries the raw pin level and a wrapping millisecond timestamp and
// yields exactly one result: three one-poll event flags and the state after
// that poll. One request per cycle is sustained while the result port is not
// stalled; a request is held in the input register, and its result is
// registered into the result register as the state update advances, which a
// stalled result port holds back; that update sets the rate. Write the
// configuration registers only while no request is in flight.
`default_nettype none
module button_press_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_pin_level,
  input  wire logic [bpc_pkg::TIME_W-1:0]    in_now_ms,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_short_press,
  output logic                               out_long_start,
  output logic                               out_long_stop,
  output logic [2:0]                         out_button_state,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bpc_pkg::MS_W-1:0]      cfg_data
);
  import bpc_pkg::*;

  bpc_cfg_t          cfg;
  bpc_res_t          res;
  bpc_res_t          res_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_pin_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              out_valid_r, out_valid_nxt;
  logic              adv;
  logic              in_take;

  assign cfg_ready = 1'b1;

  bpc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pin_r <= in_pin_level;
      s1_now_r <= in_now_ms;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  bpc_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .pin_level (s1_pin_r),
    .now_ms    (s1_now_r),
    .cfg       (cfg),
    .res       (res)
  );

  assign out_valid        = out_valid_r;
  assign out_short_press  = res_r.short_press;
  assign out_long_start   = res_r.long_start;
  assign out_long_stop    = res_r.long_stop;
  assign out_button_state = res_r.button_state;

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import bpc_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_pin_level = 1'b1;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_short_press;
  logic                 out_long_start;
  logic                 out_long_stop;
  logic [2:0]           out_button_state;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MS_W-1:0]      cfg_data = '0;

  button_press_classifier u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pin_level     (in_pin_level),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_short_press  (out_short_press),
    .out_long_start   (out_long_start),
    .out_long_stop    (out_long_stop),
    .out_button_state (out_button_state),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  bpc_state_t        cur_st = ST_IDLE;
  bpc_state_t        prev_st = ST_IDLE;
  logic [TIME_W-1:0] start_ms = '0;
  logic              cfg_act_low = 1'b1;
  logic [MS_W-1:0]   cfg_deb = 16'd50;
  logic [MS_W-1:0]   cfg_press = 16'd400;
  logic [MS_W-1:0]   cfg_long = 16'd800;

  bpc_res_t pending_events[$];
  int       mismatch_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void move_to(input bpc_state_t nxt);
    prev_st = cur_st;
    cur_st = nxt;
  endfunction

  function automatic void clear_press();
    cur_st = ST_IDLE;
    prev_st = ST_IDLE;
    start_ms = '0;
  endfunction

  function automatic bpc_res_t classify_poll(input logic pin, input logic [TIME_W-1:0] stamp);
    bpc_res_t          r;
    logic [TIME_W-1:0] el;
    logic              held;
    r = '0;
    el = stamp - start_ms;
    held = pin ^ cfg_act_low;
    case (cur_st)
      ST_IDLE: begin
        if (held) begin
          move_to(ST_PRESSED);
          start_ms = stamp;
        end
      end
      ST_PRESSED: begin
        if (!held && el < cfg_deb) begin
          move_to(prev_st);
        end else if (!held) begin
          move_to(ST_RELEASED);
          start_ms = stamp;
        end else if (el > cfg_long) begin
          r.long_start = 1'b1;
          move_to(ST_LONG);
        end
      end
      ST_RELEASED: begin
        if (held && el < cfg_deb) begin
          move_to(prev_st);
        end else if (!held && el > cfg_press) begin
          r.short_press = 1'b1;
          clear_press();
        end
      end
      ST_LONG: begin
        if (!held) begin
          move_to(ST_LONGEND);
          start_ms = stamp;
        end
      end
      default: begin
        if (held && el < cfg_deb) begin
          move_to(prev_st);
        end else if (el >= cfg_deb) begin
          r.long_stop = 1'b1;
          clear_press();
        end
      end
    endcase
    r.button_state = cur_st;
    return r;
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    bpc_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_events.pop_front();
        if (out_short_press !== want.short_press || out_long_start !== want.long_start ||
            out_long_stop !== want.long_stop || out_button_state !== want.button_state) begin
          report_mismatch($sformatf("got sp=%b ls=%b le=%b st=%0d, want sp=%b ls=%b le=%b st=%0d",
            out_short_press, out_long_start, out_long_stop, out_button_state,
            want.short_press, want.long_start, want.long_stop, want.button_state));
        end
      end
    end
  end

  task automatic send_poll(input logic pin, input logic [TIME_W-1:0] stamp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pin_level <= pin;
    in_now_ms <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_events.push_back(classify_poll(pin, stamp));
    @(negedge clk);
  endtask

  task automatic poll(input logic held, input logic [TIME_W-1:0] stamp);
    send_poll(held ^ cfg_act_low, stamp);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input bpc_cfg_idx_t idx, input logic [MS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ACTIVE_LOW: cfg_act_low = data[0];
      CFG_DEBOUNCE:   cfg_deb = data;
      CFG_PRESS:      cfg_press = data;
      CFG_LONG_PRESS: cfg_long = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [TIME_W-1:0] pick_elapsed(input logic [MS_W-1:0] lim);
    logic [TIME_W-1:0] l;
    l = {16'd0, lim};
    case ($urandom_range(0, 7))
      0: return l - 1;
      1: return l;
      2: return l + 1;
      3: return '0;
      4: return $urandom_range(0, l);
      5: return l + $urandom_range(0, 3000);
      6: return $urandom;
      default: return $urandom_range(0, 2 * l + 2);
    endcase
  endfunction

  // bias level and timing toward the thresholds of the current press state
  task automatic steer_poll();
    logic            held;
    logic [MS_W-1:0] lim;
    if ($urandom_range(0, 99) < 12) begin
      send_poll(1'($urandom_range(0, 1)), $urandom);
    end else begin
      case (cur_st)
        ST_IDLE: begin
          held = ($urandom_range(0, 99) < 80);
          lim = cfg_deb;
        end
        ST_PRESSED: begin
          held = ($urandom_range(0, 99) < 60);
          lim = held ? cfg_long : cfg_deb;
        end
        ST_RELEASED: begin
          held = ($urandom_range(0, 99) < 35);
          lim = held ? cfg_deb : cfg_press;
        end
        ST_LONG: begin
          held = ($urandom_range(0, 99) < 30);
          lim = cfg_deb;
        end
        default: begin
          held = ($urandom_range(0, 99) < 50);
          lim = cfg_deb;
        end
      endcase
      poll(held, start_ms + pick_elapsed(lim));
    end
  endtask

  task automatic test_directed_defaults();
    send_idle_pct = 23;
    recv_idle_pct = 71;
    poll(1'b0, 32'h0000_0000);
    poll(1'b1, 32'hFFFF_FFF0);
    poll(1'b0, 32'h0000_0010);
    poll(1'b1, 32'd256);
    poll(1'b1, 32'd1056);
    poll(1'b1, 32'd1057);
    poll(1'b1, 32'd2000);
    poll(1'b0, 32'd3000);
    poll(1'b1, 32'd3049);
    poll(1'b0, 32'd3100);
    poll(1'b1, 32'd3150);
    poll(1'b1, 32'd4000);
    poll(1'b0, 32'd4049);
    poll(1'b1, 32'd4100);
    poll(1'b0, 32'd4150);
    poll(1'b1, 32'd4199);
    poll(1'b0, 32'd4170);
    poll(1'b0, 32'd4550);
    poll(1'b0, 32'd4551);
    poll(1'b1, 32'hFFFF_FF00);
    poll(1'b1, 32'h0000_0300);
    poll(1'b0, 32'h0000_0400);
    poll(1'b0, 32'h0000_0500);
    drain_results();
  endtask

  task automatic test_threshold_extremes();
    write_reg(CFG_ACTIVE_LOW, 16'hFFFE);
    write_reg(CFG_DEBOUNCE, 16'h0000);
    write_reg(CFG_PRESS, 16'h0000);
    write_reg(CFG_LONG_PRESS, 16'h0000);
    repeat (40) steer_poll();
    drain_results();
    write_reg(CFG_ACTIVE_LOW, 16'hFFFF);
    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    write_reg(CFG_PRESS, 16'hFFFF);
    write_reg(CFG_LONG_PRESS, 16'hFFFF);
    repeat (40) steer_poll();
    drain_results();
  endtask

  task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 145 == 0) begin
        drain_results();
        write_reg(CFG_ACTIVE_LOW, MS_W'($urandom));
        write_reg(CFG_DEBOUNCE, MS_W'($urandom_range(0, 120)));
        write_reg(CFG_PRESS, MS_W'($urandom_range(0, 700)));
        write_reg(CFG_LONG_PRESS, MS_W'($urandom_range(0, 1500)));
      end
      steer_poll();
    end
    drain_results();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_defaults();
    test_threshold_extremes();
    test_random_traffic(580, 23, 71);
    test_random_traffic(580, 71, 23);
    test_random_traffic(580, 0, 0);
    repeat (8) @(negedge clk);
    if (pending_events.size() != 0) report_mismatch("results still pending at end");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
